@@ rtl/frame_header_crc_checker_macros.svh @@
// assertion shorthands shared by the checker modules
`ifndef FRAME_HEADER_CRC_CHECKER_MACROS_SVH
`define FRAME_HEADER_CRC_CHECKER_MACROS_SVH

// same-cycle implication, quiet during reset
`define FHCC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define FHCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fhcc_pkg.sv @@
package fhcc_pkg;

   // frame layout
   localparam int unsigned HDR_BYTES       = 24;
   localparam int unsigned TRAILER_BYTES   = 4;
   localparam int unsigned MIN_FRAME_BYTES = HDR_BYTES + TRAILER_BYTES;
   localparam int unsigned DEFAULT_MAX_FRAME_BYTES = 256;

   localparam logic [7:0]  MAGIC_A       = 8'h45;
   localparam logic [7:0]  MAGIC_B       = 8'h53;
   localparam logic [7:0]  FRAME_VERSION = 8'h01;
   localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;

   localparam logic [15:0] SLACK_RESET   = 16'd15;

   // result queue depth
   localparam int unsigned RSP_FIFO_DEPTH = 3;

   // bus widths
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 184;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_LONG     = 3'd2,
      ST_BAD_HDR  = 3'd3,
      ST_CRC_FAIL = 3'd4,
      ST_STALE    = 3'd5
   } status_type;

   typedef struct packed {
      logic [31:0] peer_time;
      logic        last_byte;
      logic [7:0]  byte_value;
   } in_word_type;

   typedef struct packed {
      kind_type    item_kind;
      logic [31:0] frame_time;
      logic [63:0] nonce_count;
      logic [63:0] frame_seq;
      logic [7:0]  payload_length;
      status_type  status;
      logic [7:0]  payload_byte;
   } rsp_item_type;

   // reflected crc-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] v;
      v = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v;
   endfunction

endpackage

@@ rtl/frame_header_crc_checker.sv @@
// Byte-wide frame deframer: each request word carries one frame byte, tlast on the
// final byte and the peer time. The 24-byte header (magic 0x45 0x53, version 1,
// flags, timestamp, sequence, nonce) is captured, a reflected CRC-32 runs over all
// bytes but the last four, and those are checked as the little-endian trailer.
// Payload bytes come out four bytes behind the input with tuser 0; the last byte
// adds a status word with tuser 1 (ok, short, long, bad header, crc fail, stale
// time, first failing check wins). A byte is taken every cycle while the input
// register is empty or hands its word on; each word is processed while it sits
// in the input register, and its results enter a three-word result queue as it
// moves on, so a response word passes the input register and then the queue.
// The input register hands a word on whenever the queue has room for every word
// that it adds, so bytes follow back to back while the consumer takes one word
// per cycle. Bytes past MAX_FRAME_BYTES are dropped and the frame reports long.
// The slack register may be written only while idle.
module frame_header_crc_checker #(
   parameter int unsigned MAX_FRAME_BYTES = fhcc_pkg::DEFAULT_MAX_FRAME_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: [7:0] byte_value, [39:8] peer_time
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fhcc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   // response: [7:0] payload_byte, [10:8] status, [18:11] payload_length,
   // [82:19] frame_seq, [146:83] nonce_count, [178:147] frame_time, rest zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fhcc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // response tuser: [0] item_kind
   output logic                              rsp_tuser,
   // timestamp slack register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [15:0]                       csr_data
);
   import fhcc_pkg::*;

   localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);

   // input stage
   in_word_type   in_ff, in_in;
   logic          in_valid_ff, in_valid_in;
   logic          req_accept;
   logic          fire;
   logic [1:0]    fifo_level;

   // frame state
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   crc_ff, crc_in;
   logic [7:0]    delay_ff [4];
   logic [7:0]    delay_in [4];
   logic          header_ok_ff, header_ok_in;
   logic [31:0]   hdr_time_ff, hdr_time_in;
   logic [63:0]   hdr_seq_ff, hdr_seq_in;
   logic [63:0]   hdr_nonce_ff, hdr_nonce_in;
   logic          overflow_ff, overflow_in;
   logic [15:0]   slack_ff;

   // per-word work
   logic [CW-1:0] idx;
   logic          saturated;
   logic          emit_payload;
   logic [CW-1:0] plen_wide;
   logic [7:0]    plen;
   logic [31:0]   rx_crc;
   logic [31:0]   time_diff;
   status_type    status;
   rsp_item_type  pay_item, stat_item, rsp_item;
   logic [1:0]    push_need;
   logic [1:0]    push_count;

   assign csr_ready = 1'b1;

   // slack register
   always_ff @(posedge clock) begin
      if (reset) begin
         slack_ff <= SLACK_RESET;
      end else if (csr_valid) begin
         slack_ff <= csr_data;
      end
   end

   // input register and handshake, held word moves on when the queue has room
   assign push_need  = {1'b0, emit_payload} + {1'b0, in_ff.last_byte};
   assign fire       = in_valid_ff &&
                       (({1'b0, fifo_level} + {1'b0, push_need}) <= 3'(RSP_FIFO_DEPTH));
   assign req_tready = !in_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff && !fire;
      if (req_accept) begin
         in_in.byte_value = req_tdata[7:0];
         in_in.peer_time  = req_tdata[39:8];
         in_in.last_byte  = req_tlast;
         in_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   // byte update: delay line, header capture, crc
   assign idx          = count_ff;
   assign saturated    = (count_ff >= CW'(MAX_FRAME_BYTES));
   assign emit_payload = !saturated && (idx >= CW'(MIN_FRAME_BYTES));

   always_comb begin
      count_in     = count_ff;
      crc_in       = crc_ff;
      delay_in     = delay_ff;
      header_ok_in = header_ok_ff;
      hdr_time_in  = hdr_time_ff;
      hdr_seq_in   = hdr_seq_ff;
      hdr_nonce_in = hdr_nonce_ff;
      overflow_in  = overflow_ff;
      if (saturated) begin
         overflow_in = 1'b1;
      end else begin
         delay_in[0] = delay_ff[1];
         delay_in[1] = delay_ff[2];
         delay_in[2] = delay_ff[3];
         delay_in[3] = in_ff.byte_value;
         priority if (idx == CW'(0)) begin
            if (in_ff.byte_value != MAGIC_A) header_ok_in = 1'b0;
         end else if (idx == CW'(1)) begin
            if (in_ff.byte_value != MAGIC_B) header_ok_in = 1'b0;
         end else if (idx == CW'(2)) begin
            if (in_ff.byte_value != FRAME_VERSION) header_ok_in = 1'b0;
         end else if (idx >= CW'(4) && idx < CW'(8)) begin
            hdr_time_in[{idx[1:0], 3'b000} +: 8] = in_ff.byte_value;
         end else if (idx >= CW'(8) && idx < CW'(16)) begin
            hdr_seq_in[{idx[2:0], 3'b000} +: 8] = in_ff.byte_value;
         end else if (idx >= CW'(16) && idx < CW'(HDR_BYTES)) begin
            hdr_nonce_in[{idx[2:0], 3'b000} +: 8] = in_ff.byte_value;
         end else begin
            header_ok_in = header_ok_ff;
         end
         if (idx >= CW'(TRAILER_BYTES)) begin
            crc_in = crc_byte(crc_ff, delay_ff[0]);
         end
         count_in = idx + CW'(1);
      end
   end

   // end-of-frame checks on the updated state
   assign rx_crc    = {delay_in[3], delay_in[2], delay_in[1], delay_in[0]};
   assign time_diff = (in_ff.peer_time > hdr_time_ff) ? (in_ff.peer_time - hdr_time_ff)
                                                       : (hdr_time_ff - in_ff.peer_time);
   assign plen_wide = count_in - CW'(MIN_FRAME_BYTES);

   always_comb begin
      if (count_in < CW'(MIN_FRAME_BYTES)) begin
         plen = 8'd0;
      end else if (32'(plen_wide) > 32'd255) begin
         plen = 8'hFF;
      end else begin
         plen = 8'(plen_wide);
      end
   end

   // header time and header_ok are complete whenever the frame is long enough
   always_comb begin
      priority if (count_in < CW'(MIN_FRAME_BYTES)) begin
         status = ST_SHORT;
      end else if (overflow_in) begin
         status = ST_LONG;
      end else if (!header_ok_ff) begin
         status = ST_BAD_HDR;
      end else if (rx_crc != ~crc_in) begin
         status = ST_CRC_FAIL;
      end else if (time_diff > {16'd0, slack_ff}) begin
         status = ST_STALE;
      end else begin
         status = ST_OK;
      end
   end

   // result words
   always_comb begin
      pay_item                = '0;
      pay_item.item_kind      = KIND_PAYLOAD;
      pay_item.status         = ST_OK;
      pay_item.payload_byte   = delay_ff[0];

      stat_item               = '0;
      stat_item.item_kind     = KIND_STATUS;
      stat_item.status        = status;
      stat_item.payload_length = plen;
      stat_item.frame_seq     = hdr_seq_in;
      stat_item.nonce_count   = hdr_nonce_in;
      stat_item.frame_time    = hdr_time_in;
   end

   always_comb begin
      push_count = 2'd0;
      if (fire) begin
         push_count = push_need;
      end
   end

   // frame state registers, cleared after each last byte
   always_ff @(posedge clock) begin
      if (reset || (fire && in_ff.last_byte)) begin
         count_ff     <= '0;
         crc_ff       <= CRC_INIT;
         delay_ff     <= '{default: 8'd0};
         header_ok_ff <= 1'b1;
         hdr_time_ff  <= '0;
         hdr_seq_ff   <= '0;
         hdr_nonce_ff <= '0;
         overflow_ff  <= 1'b0;
      end else if (fire) begin
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         delay_ff     <= delay_in;
         header_ok_ff <= header_ok_in;
         hdr_time_ff  <= hdr_time_in;
         hdr_seq_ff   <= hdr_seq_in;
         hdr_nonce_ff <= hdr_nonce_in;
         overflow_ff  <= overflow_in;
      end
   end

   fhcc_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_item_a (emit_payload ? pay_item : stat_item),
      .push_item_b (stat_item),
      .level       (fifo_level),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_item    (rsp_item)
   );

   assign rsp_tuser = rsp_item.item_kind;
   assign rsp_tdata = {5'd0, rsp_item.frame_time, rsp_item.nonce_count,
                       rsp_item.frame_seq, rsp_item.payload_length,
                       rsp_item.status, rsp_item.payload_byte};

`include "frame_header_crc_checker_macros.svh"

   `FHCC_ASSERT_NEXT(a_frame_cleared, fire && in_ff.last_byte, count_ff == '0 && !overflow_ff, "frame state not cleared after last word")
   `FHCC_ASSERT_NOW(a_overflow_full, overflow_ff, count_ff == CW'(MAX_FRAME_BYTES), "overflow before frame limit")
   `FHCC_ASSERT_NOW(a_bad_hdr_seen, !header_ok_ff, count_ff != '0, "header marked bad before any byte")
   `FHCC_ASSERT_NEXT(a_held_word, in_valid_ff && !fire, in_valid_ff && $stable(in_ff), "input word lost while stalled")

endmodule

@@ rtl/fhcc_rsp_fifo.sv @@
module fhcc_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  fhcc_pkg::rsp_item_type push_item_a,
   input  fhcc_pkg::rsp_item_type push_item_b,
   output logic [1:0]            level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fhcc_pkg::rsp_item_type rsp_item
);
   import fhcc_pkg::*;

   localparam int unsigned DEPTH = RSP_FIFO_DEPTH;
   localparam int unsigned PW    = $clog2(DEPTH);

   rsp_item_type      entries_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [1:0]        level_ff, level_in;
   logic              pop;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign pop       = (level_ff != 2'd0) && rsp_ready;
   assign rsp_valid = (level_ff != 2'd0);
   assign rsp_item  = entries_ff[rd_ptr_ff];
   assign level     = level_ff;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_count == 2'd1) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
      end else if (push_count == 2'd2) begin
         wr_ptr_in = next_ptr(next_ptr(wr_ptr_ff));
      end
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff + push_count - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage, first word then second
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_item_a;
      end
      if (push_count == 2'd2) begin
         entries_ff[next_ptr(wr_ptr_ff)] <= push_item_b;
      end
   end

`include "frame_header_crc_checker_macros.svh"

   `FHCC_ASSERT_NOW(a_level_in_range, 1'b1, level_ff <= 2'(DEPTH), "fifo level above depth")
   `FHCC_ASSERT_NOW(a_no_overrun, push_count != 2'd0, {1'b0, level_ff} + {1'b0, push_count} <= 3'(DEPTH), "push into full fifo")
   `FHCC_ASSERT_NOW(a_ptr_gap, (level_ff != 2'd0) && (level_ff != 2'(DEPTH)), rd_ptr_ff != wr_ptr_ff, "pointers disagree with level")

endmodule
